// ----- rtl/pfc_pkg.sv -----
// ----------------------------------------------------------------------------
// pfc_pkg: shared definitions for the Playfair digraph cipher
// Letter codes, register indexes, square types and the square lookup helpers.
// ----------------------------------------------------------------------------
package pfc_pkg;

    // Letter codes, A = 0 .. Z = 25.
    localparam int unsigned CODE_W = 5;
    localparam logic [CODE_W-1:0] LETTER_I = 5'd8;
    localparam logic [CODE_W-1:0] LETTER_J = 5'd9;
    localparam logic [CODE_W-1:0] LETTER_X = 5'd23;
    localparam logic [CODE_W-1:0] LETTER_Z = 5'd25;

    // Square geometry.
    localparam int unsigned SIDE  = 5;
    localparam int unsigned POS_W = 3;
    localparam int unsigned ROW_W = SIDE * CODE_W;

    // ASCII forms.
    localparam int unsigned CHAR_W  = 8;
    localparam int unsigned ASCII_W = 7;
    localparam logic [CHAR_W-1:0]  ASC_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0]  ASC_UPPER_Z = 8'h5A;
    localparam logic [CHAR_W-1:0]  ASC_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0]  ASC_LOWER_Z = 8'h7A;
    localparam logic [ASCII_W-1:0] ASC_A7      = 7'h41;

    // Configuration register indexes.
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_0 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_1 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_2 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_3 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_4 = 3'd5;

    // Mode codes.
    localparam logic MODE_ENC = 1'b0;
    localparam logic MODE_DEC = 1'b1;

    // Reset square: A..Z without J, in row-major order.
    localparam logic [ROW_W-1:0] SQ_RST_0 = 25'd4294688;
    localparam logic [ROW_W-1:0] SQ_RST_1 = 25'd10755269;
    localparam logic [ROW_W-1:0] SQ_RST_2 = 25'd16201099;
    localparam logic [ROW_W-1:0] SQ_RST_3 = 25'd21613104;
    localparam logic [ROW_W-1:0] SQ_RST_4 = 25'd27025109;

    typedef logic [SIDE-1:0][ROW_W-1:0] t_square;

    typedef struct packed {
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
    } t_pos;

    typedef struct packed {
        logic [CODE_W-1:0] a;
        logic [CODE_W-1:0] b;
    } t_pair;

    // Entry of the square at a row and column, both below SIDE.
    function automatic logic [CODE_W-1:0] pfc_cell(t_square sq, logic [POS_W-1:0] r,
                                                   logic [POS_W-1:0] c);
        return sq[r][c*CODE_W +: CODE_W];
    endfunction

    // Position of a letter; the first match in row-major order wins, and a
    // letter found nowhere sits at row 0, column 0.
    function automatic t_pos pfc_locate(t_square sq, logic [CODE_W-1:0] code);
        t_pos p;
        p.row = '0;
        p.col = '0;
        for (int r = SIDE - 1; r >= 0; r--) begin
            for (int c = SIDE - 1; c >= 0; c--) begin
                if (sq[r][c*CODE_W +: CODE_W] == code) begin
                    p.row = POS_W'(r);
                    p.col = POS_W'(c);
                end
            end
        end
        return p;
    endfunction

    // One step around the square, forward for encrypt and back for decrypt.
    function automatic logic [POS_W-1:0] pfc_step(logic [POS_W-1:0] v, logic dec);
        logic [POS_W-1:0] s;
        if (dec) begin
            s = (v == '0) ? POS_W'(SIDE - 1) : v - 1'b1;
        end else begin
            s = (v == POS_W'(SIDE - 1)) ? '0 : v + 1'b1;
        end
        return s;
    endfunction

    // Playfair rules for one digraph.
    function automatic t_pair pfc_cipher(t_square sq, t_pair din, logic dec);
        t_pos  p1;
        t_pos  p2;
        t_pair q;
        p1 = pfc_locate(sq, din.a);
        p2 = pfc_locate(sq, din.b);
        if (p1.row == p2.row) begin
            q.a = pfc_cell(sq, p1.row, pfc_step(p1.col, dec));
            q.b = pfc_cell(sq, p2.row, pfc_step(p2.col, dec));
        end else if (p1.col == p2.col) begin
            q.a = pfc_cell(sq, pfc_step(p1.row, dec), p1.col);
            q.b = pfc_cell(sq, pfc_step(p2.row, dec), p2.col);
        end else begin
            q.a = pfc_cell(sq, p1.row, p2.col);
            q.b = pfc_cell(sq, p2.row, p1.col);
        end
        return q;
    endfunction

    // Letter code to ASCII upper case; codes past Z print as X.
    function automatic logic [ASCII_W-1:0] pfc_ascii(logic [CODE_W-1:0] code);
        logic [CODE_W-1:0] c;
        c = (code > LETTER_Z) ? LETTER_X : code;
        return ASC_A7 + ASCII_W'(c);
    endfunction

endpackage

// ----- rtl/playfair_digraph_cipher.sv -----
// ----------------------------------------------------------------------------
// playfair_digraph_cipher: streaming Playfair encrypt / decrypt
// Folds text bytes to letter codes, pairs them, and maps each digraph
// through a 5x5 square held in configuration registers.
// ----------------------------------------------------------------------------
//  Channel  | Direction | Handshake          | Payload
//  ---------+-----------+--------------------+------------------------------------
//  input    | in        | i_in_valid/o_in_stall   | i_char_in, i_end_of_text
//  output   | out       | o_out_valid/i_out_stall | o_first_letter, o_second_letter,
//           |           |                    | o_final_pair
//  config   | in        | i_cfg_valid/o_cfg_ready | i_cfg_index, i_cfg_data
//
// One byte is taken per cycle while o_in_stall is low. The pairing decision
// is made as the byte is taken; each digraph then passes through the request
// register and the output register, with the square lookup in between.
// A final byte with two digraphs stalls input until both have moved on.
// Reset (synchronous, active low) empties both stages, clears the waiting
// letter and restores encrypt mode and the default square.
// Output stall backs up through the request register to o_in_stall.
// ----------------------------------------------------------------------------
module playfair_digraph_cipher (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Input text channel
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [pfc_pkg::CHAR_W-1:0]     i_char_in,
    input  logic                           i_end_of_text,
    // Output digraph channel
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [pfc_pkg::ASCII_W-1:0]    o_first_letter,
    output logic [pfc_pkg::ASCII_W-1:0]    o_second_letter,
    output logic                           o_final_pair,
    // Configuration write channel
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [pfc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [pfc_pkg::ROW_W-1:0]      i_cfg_data
);
    import pfc_pkg::*;

    // Configuration state.
    logic    r_mode;
    t_square r_square;

    // Letter waiting for its partner.
    logic              r_held_valid;
    logic [CODE_W-1:0] r_held_letter;
    logic              n_held_valid;
    logic [CODE_W-1:0] n_held_letter;

    // Request register: one or two digraphs from the last accepted byte.
    logic              r_req_valid;
    logic              r_req_two;
    logic              r_req_sel;
    t_pair             r_req_pair0;
    logic              r_req_final0;
    logic [CODE_W-1:0] r_req_second;

    // Output register.
    logic               r_out_valid;
    logic [ASCII_W-1:0] r_out_first;
    logic [ASCII_W-1:0] r_out_second;
    logic               r_out_final;

    // Decode and pairing for the incoming byte.
    logic              in_accept;
    logic              is_letter;
    logic [CODE_W-1:0] code;
    logic              p0_valid;
    t_pair             p0_pair;
    logic              p0_final;
    logic              p1_valid;
    logic [CODE_W-1:0] p1_letter;

    // Drain control.
    logic  out_load;
    logic  req_done;
    t_pair cur_pair;
    logic  cur_final;
    t_pair enc_pair;

    assign o_cfg_ready = 1'b1;

    // Configuration writes; indexes past the last row are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_ENC;
            r_square[0] <= SQ_RST_0;
            r_square[1] <= SQ_RST_1;
            r_square[2] <= SQ_RST_2;
            r_square[3] <= SQ_RST_3;
            r_square[4] <= SQ_RST_4;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_MODE:  r_mode      <= i_cfg_data[0];
                CFG_ROW_0: r_square[0] <= i_cfg_data;
                CFG_ROW_1: r_square[1] <= i_cfg_data;
                CFG_ROW_2: r_square[2] <= i_cfg_data;
                CFG_ROW_3: r_square[3] <= i_cfg_data;
                CFG_ROW_4: r_square[4] <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Fold the byte to a letter code, with J read as I.
    always_comb begin
        is_letter = 1'b0;
        code      = '0;
        if (i_char_in >= ASC_UPPER_A && i_char_in <= ASC_UPPER_Z) begin
            is_letter = 1'b1;
            code      = CODE_W'(i_char_in - ASC_UPPER_A);
        end else if (i_char_in >= ASC_LOWER_A && i_char_in <= ASC_LOWER_Z) begin
            is_letter = 1'b1;
            code      = CODE_W'(i_char_in - ASC_LOWER_A);
        end
        if (code == LETTER_J) begin
            code = LETTER_I;
        end
    end

    // Pairing rules, including the doubled letter split (encrypt mode) and end-of-text padding.
    always_comb begin
        n_held_valid  = r_held_valid;
        n_held_letter = r_held_letter;
        p0_valid      = 1'b0;
        p0_pair.a     = r_held_letter;
        p0_pair.b     = LETTER_X;
        p0_final      = 1'b0;
        p1_valid      = 1'b0;
        p1_letter     = code;
        if (is_letter) begin
            if (!r_held_valid) begin
                if (i_end_of_text) begin
                    p0_valid  = 1'b1;
                    p0_pair.a = code;
                    p0_final  = 1'b1;
                end else begin
                    n_held_valid  = 1'b1;
                    n_held_letter = code;
                end
            end else if (r_mode == MODE_ENC && r_held_letter == code) begin
                p0_valid = 1'b1;
                if (i_end_of_text) begin
                    p1_valid = 1'b1;
                end else begin
                    n_held_letter = code;
                end
            end else begin
                p0_valid      = 1'b1;
                p0_pair.b     = code;
                p0_final      = i_end_of_text;
                n_held_valid  = 1'b0;
                n_held_letter = '0;
            end
        end else if (i_end_of_text && r_held_valid) begin
            p0_valid = 1'b1;
            p0_final = 1'b1;
        end
        if (i_end_of_text) begin
            n_held_valid  = 1'b0;
            n_held_letter = '0;
        end
    end

    // Handshake: the request register frees once its last digraph moves on.
    assign out_load   = !r_out_valid || !i_out_stall;
    assign req_done   = r_req_valid && out_load && (r_req_sel || !r_req_two);
    assign o_in_stall = r_req_valid && !req_done;
    assign in_accept  = i_in_valid && !o_in_stall;

    // Waiting letter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_valid  <= 1'b0;
            r_held_letter <= '0;
        end else if (in_accept) begin
            r_held_valid  <= n_held_valid;
            r_held_letter <= n_held_letter;
        end
    end

    // Request register control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_valid <= 1'b0;
            r_req_sel   <= 1'b0;
        end else if (in_accept) begin
            r_req_valid <= p0_valid;
            r_req_sel   <= 1'b0;
        end else if (r_req_valid && out_load) begin
            if (req_done) begin
                r_req_valid <= 1'b0;
            end else begin
                r_req_sel <= 1'b1;
            end
        end
    end

    // Request register payload.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_req_two    <= p1_valid;
            r_req_pair0  <= p0_pair;
            r_req_final0 <= p0_final;
            r_req_second <= p1_letter;
        end
    end

    // The second digraph of a final doubled letter is always padded and final.
    always_comb begin
        if (r_req_sel) begin
            cur_pair.a = r_req_second;
            cur_pair.b = LETTER_X;
            cur_final  = 1'b1;
        end else begin
            cur_pair   = r_req_pair0;
            cur_final  = r_req_final0;
        end
    end

    // Square lookup for the digraph on its way to the output register.
    assign enc_pair = pfc_cipher(r_square, cur_pair, r_mode == MODE_DEC);

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= r_req_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_first  <= pfc_ascii(enc_pair.a);
            r_out_second <= pfc_ascii(enc_pair.b);
            r_out_final  <= cur_final;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_first_letter  = r_out_first;
    assign o_second_letter = r_out_second;
    assign o_final_pair    = r_out_final;

endmodule
